// ===== design/afw_pkg.sv =====
// Shared types and constants for the aspect fit window calculator.
// Used by every module of the block; depends on nothing else.
package afw_pkg;

   localparam int DW          = 13;
   localparam int PW          = 2 * DW;
   localparam int DIV_STEP    = 7;
   localparam int DIV_STAGES  = (PW + DIV_STEP - 1) / DIV_STEP;
   localparam int QW          = DIV_STAGES * DIV_STEP;
   localparam int OSD_W       = 16;
   localparam int OFS_W       = 15;
   localparam int CLAMP_W     = 17;
   localparam int CSR_IDX_W   = 4;
   localparam int FRONT_STAGES = 3;
   localparam int BACK_STAGES  = 3;
   localparam int LATENCY     = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

   localparam logic [DW-1:0] PANEL_W_RESET = 13'd1920;
   localparam logic [DW-1:0] PANEL_H_RESET = 13'd1080;
   localparam logic [OSD_W-1:0] OSD_MAX    = 16'hFFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_PANEL_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PANEL_HEIGHT = 4'd1;

   localparam logic [2:0] MODE_NONE     = 3'd0;
   localparam logic [2:0] MODE_PRE_FIT  = 3'd1;
   localparam logic [2:0] MODE_PRE_FILL = 3'd2;
   localparam logic [2:0] MODE_POST_FIT = 3'd3;
   localparam logic [2:0] MODE_POST_NAT = 3'd4;

   typedef enum logic [1:0] {
      ST_OK,
      ST_OVERSIZE,
      ST_BAD_MODE
   } afw_status_type;

   typedef struct packed {
      logic [DW-1:0] src_width;
      logic [DW-1:0] src_height;
      logic [2:0]    fit_mode;
   } afw_req_type;

   typedef struct packed {
      afw_status_type   status;
      logic [DW-1:0]    win_width;
      logic [DW-1:0]    win_height;
      logic [OFS_W-1:0] win_x;
      logic [OFS_W-1:0] win_y;
      logic [OSD_W-1:0] osd_w;
      logic [OSD_W-1:0] osd_h;
   } afw_rsp_type;

   typedef struct packed {
      logic [2:0]    mode;
      logic [DW-1:0] w;
      logic [DW-1:0] h;
      logic [DW-1:0] pw;
      logic [DW-1:0] ph;
      logic          wide;
   } afw_side_type;

   typedef struct packed {
      logic [QW-1:0] num;
      logic [DW-1:0] den;
      afw_side_type  side;
   } afw_div_type;

   typedef struct packed {
      logic [QW-1:0] quo;
      logic [DW-1:0] rem;
      logic [DW-1:0] den;
      afw_side_type  side;
   } afw_quo_type;

endpackage

// ===== design/aspect_fit_window_calc_top.sv =====
// Top level of the aspect fit window calculator: panel registers and pipeline.
// Depends on afw_pkg, afw_front, afw_div and afw_back.
//
// Usage: a request item (source width, height and fit mode) is taken on a
// rising edge where start is high and busy is low. Busy is low at all times
// except in the cycle right after reset, so one item can enter every cycle.
// Each item gives exactly one result item on rsp_item, marked by rsp_strobe
// for one cycle, after it passes three front stages (clamp, cross-products,
// operand select), four divider stages of seven quotient bits each, and
// three back stages (round, clamp, offsets).
// Throughput is one item per cycle; the receiver cannot stall the result,
// so the pipeline never holds.
// The panel size is written through the csr_ port, which is always ready;
// index 0 is the panel width and index 1 the panel height. Write it only
// while no item is in flight.
// Synchronous reset empties the pipeline and sets the panel to 1920 x 1080.
module aspect_fit_window_calc_top #(
   parameter int DIM_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  afw_pkg::afw_req_type            req_item,
   output logic                            rsp_strobe,
   output afw_pkg::afw_rsp_type            rsp_item,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [afw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [afw_pkg::DW-1:0]          csr_wdata
);
   import afw_pkg::*;

   logic          busy_ff;
   logic [DW-1:0] panel_w_ff, panel_h_ff;
   logic          accept;
   logic          front_valid, div_valid;
   afw_div_type   front_div;
   afw_quo_type   div_quo;

   assign accept    = start & ~busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         panel_w_ff <= PANEL_W_RESET;
         panel_h_ff <= PANEL_H_RESET;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid && csr_ready && csr_index == CSR_PANEL_WIDTH) begin
            panel_w_ff <= csr_wdata;
         end
         if (csr_valid && csr_ready && csr_index == CSR_PANEL_HEIGHT) begin
            panel_h_ff <= csr_wdata;
         end
      end
   end

   afw_front #(
      .DIM_BITS (DIM_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .i_valid   (accept),
      .i_req     (req_item),
      .i_panel_w (panel_w_ff),
      .i_panel_h (panel_h_ff),
      .o_valid   (front_valid),
      .o_div     (front_div)
   );

   afw_div u_div (
      .clock   (clock),
      .reset   (reset),
      .i_valid (front_valid),
      .i_div   (front_div),
      .o_valid (div_valid),
      .o_quo   (div_quo)
   );

   afw_back u_back (
      .clock   (clock),
      .reset   (reset),
      .i_valid (div_valid),
      .i_quo   (div_quo),
      .o_valid (rsp_strobe),
      .o_rsp   (rsp_item)
   );

   // Every accepted item comes out as a result on rsp_strobe after the whole pipeline.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("accepted item did not produce a result on time");

   // Any error status clears the window and plane fields.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.status != ST_OK |->
         rsp_item.win_width == '0 && rsp_item.win_height == '0 &&
         rsp_item.osd_w == '0 && rsp_item.osd_h == '0 &&
         rsp_item.win_x == '0 && rsp_item.win_y == '0)
      else $error("error result carries nonzero fields");

   // A good result never has a window larger than its plane.
   a_fits: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.status == ST_OK |->
         rsp_item.osd_w >= OSD_W'(rsp_item.win_width) &&
         rsp_item.osd_h >= OSD_W'(rsp_item.win_height))
      else $error("window exceeds plane");

   // The panel registers change only on a configuration write.
   a_panel_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(csr_valid) |-> $stable(panel_w_ff) && $stable(panel_h_ff))
      else $error("panel size changed without a write");

endmodule

// ===== design/afw_front.sv =====
// Front stages: dimension clamp, cross-products, and divider operand select.
// Depends on afw_pkg.
module afw_front #(
   parameter int DIM_BITS = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 i_valid,
   input  afw_pkg::afw_req_type i_req,
   input  logic [afw_pkg::DW-1:0] i_panel_w,
   input  logic [afw_pkg::DW-1:0] i_panel_h,
   output logic                 o_valid,
   output afw_pkg::afw_div_type o_div
);
   import afw_pkg::*;

   localparam int unsigned DIM_MAX = 1 << DIM_BITS;

   function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
      logic [CLAMP_W-1:0] vx;
      vx = CLAMP_W'(v);
      if (v == '0) begin
         return DW'(1);
      end
      if (vx > DIM_MAX[CLAMP_W-1:0]) begin
         return DIM_MAX[DW-1:0];
      end
      return v;
   endfunction

   logic         v1_ff, v2_ff, v3_ff;
   afw_side_type side1_ff, side1_in;
   afw_side_type side2_ff;
   logic [PW-1:0] a2_ff, b2_ff, a2_in, b2_in;
   afw_div_type  div3_ff, div3_in;
   logic         wide;

   always_comb begin
      side1_in.mode = i_req.fit_mode;
      side1_in.w    = clamp_dim(i_req.src_width);
      side1_in.h    = clamp_dim(i_req.src_height);
      side1_in.pw   = clamp_dim(i_panel_w);
      side1_in.ph   = clamp_dim(i_panel_h);
      side1_in.wide = 1'b0;
   end

   assign a2_in = PW'(side1_ff.w) * PW'(side1_ff.ph);
   assign b2_in = PW'(side1_ff.pw) * PW'(side1_ff.h);
   assign wide  = (a2_ff >= b2_ff);

   always_comb begin
      div3_in.side      = side2_ff;
      div3_in.side.wide = wide;
      div3_in.num       = QW'(a2_ff);
      div3_in.den       = side2_ff.w;
      unique case ({side2_ff.mode == MODE_POST_FIT, wide})
         2'b00: begin
            div3_in.num = QW'(a2_ff);
            div3_in.den = side2_ff.h;
         end
         2'b01: begin
            div3_in.num = QW'(b2_ff);
            div3_in.den = side2_ff.w;
         end
         2'b10: begin
            div3_in.num = QW'(b2_ff);
            div3_in.den = side2_ff.ph;
         end
         default: begin
            div3_in.num = QW'(a2_ff);
            div3_in.den = side2_ff.pw;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= i_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      side1_ff <= side1_in;
      side2_ff <= side1_ff;
      a2_ff    <= a2_in;
      b2_ff    <= b2_in;
      div3_ff  <= div3_in;
   end

   assign o_valid = v3_ff;
   assign o_div   = div3_ff;

endmodule

// ===== design/afw_div.sv =====
// Pipelined restoring divider, a fixed number of quotient bits per stage.
// Carries the item's side fields alongside; depends on afw_pkg.
module afw_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 i_valid,
   input  afw_pkg::afw_div_type i_div,
   output logic                 o_valid,
   output afw_pkg::afw_quo_type o_quo
);
   import afw_pkg::*;

   logic          valid_ff [DIV_STAGES];
   logic [QW-1:0] nq_ff    [DIV_STAGES];
   logic [DW-1:0] rem_ff   [DIV_STAGES];
   logic [DW-1:0] den_ff   [DIV_STAGES];
   afw_side_type  side_ff  [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic          valid_src;
      logic [QW-1:0] nq_src, nq_in;
      logic [DW-1:0] rem_src, rem_in, den_src;
      afw_side_type  side_src;
      logic [DW:0]   trial;

      if (s == 0) begin : g_first
         assign valid_src = i_valid;
         assign nq_src    = i_div.num;
         assign rem_src   = '0;
         assign den_src   = i_div.den;
         assign side_src  = i_div.side;
      end else begin : g_next
         assign valid_src = valid_ff[s-1];
         assign nq_src    = nq_ff[s-1];
         assign rem_src   = rem_ff[s-1];
         assign den_src   = den_ff[s-1];
         assign side_src  = side_ff[s-1];
      end

      always_comb begin
         nq_in  = nq_src;
         rem_in = rem_src;
         trial  = '0;
         for (int k = 0; k < DIV_STEP; k++) begin
            trial = {rem_in, nq_in[QW-1]};
            nq_in = {nq_in[QW-2:0], 1'b0};
            if (trial >= {1'b0, den_src}) begin
               trial    = trial - {1'b0, den_src};
               nq_in[0] = 1'b1;
            end
            rem_in = trial[DW-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_src;
         end
         nq_ff[s]   <= nq_in;
         rem_ff[s]  <= rem_in;
         den_ff[s]  <= den_src;
         side_ff[s] <= side_src;
      end
   end

   assign o_valid    = valid_ff[DIV_STAGES-1];
   assign o_quo.quo  = nq_ff[DIV_STAGES-1];
   assign o_quo.rem  = rem_ff[DIV_STAGES-1];
   assign o_quo.den  = den_ff[DIV_STAGES-1];
   assign o_quo.side = side_ff[DIV_STAGES-1];

endmodule

// ===== design/afw_back.sv =====
// Back stages: rounding, clamp and saturation per mode, centering offsets.
// Depends on afw_pkg.
module afw_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 i_valid,
   input  afw_pkg::afw_quo_type i_quo,
   output logic                 o_valid,
   output afw_pkg::afw_rsp_type o_rsp
);
   import afw_pkg::*;

   function automatic logic [OSD_W-1:0] sat_osd(input logic [QW-1:0] v);
      if (v > QW'(OSD_MAX)) begin
         return OSD_MAX;
      end
      return v[OSD_W-1:0];
   endfunction

   logic           v1_ff, v2_ff, v3_ff;
   logic [QW-1:0]  qr1_ff, qr1_in;
   afw_side_type   side1_ff;
   logic           round_up;

   afw_status_type st2_ff, st2_in;
   logic [DW-1:0]  ww2_ff, wh2_ff, ww2_in, wh2_in;
   logic [OSD_W-1:0] ow2_ff, oh2_ff, ow2_in, oh2_in;
   logic [QW-1:0]  wx_full, hx_full;

   afw_rsp_type    rsp3_ff, rsp3_in;
   logic [OSD_W-1:0] dx, dy;

   assign round_up = ({i_quo.rem, 1'b0} >= {1'b0, i_quo.den});
   assign qr1_in   = i_quo.quo + QW'(round_up);

   assign wx_full = (qr1_ff > QW'(side1_ff.w)) ? qr1_ff : QW'(side1_ff.w);
   assign hx_full = (qr1_ff > QW'(side1_ff.h)) ? qr1_ff : QW'(side1_ff.h);

   always_comb begin
      st2_in = ST_OK;
      ww2_in = side1_ff.w;
      wh2_in = side1_ff.h;
      ow2_in = OSD_W'(side1_ff.pw);
      oh2_in = OSD_W'(side1_ff.ph);
      unique case (side1_ff.mode)
         MODE_NONE: begin
            if (side1_ff.w > side1_ff.pw || side1_ff.h > side1_ff.ph) begin
               st2_in = ST_OVERSIZE;
            end
         end
         MODE_PRE_FIT: begin
            if (side1_ff.wide) begin
               ww2_in = side1_ff.pw;
               wh2_in = (qr1_ff > QW'(side1_ff.ph)) ? side1_ff.ph : qr1_ff[DW-1:0];
            end else begin
               wh2_in = side1_ff.ph;
               ww2_in = (qr1_ff > QW'(side1_ff.pw)) ? side1_ff.pw : qr1_ff[DW-1:0];
            end
         end
         MODE_PRE_FILL: begin
            ww2_in = side1_ff.pw;
            wh2_in = side1_ff.ph;
         end
         MODE_POST_FIT: begin
            if (side1_ff.wide) begin
               ow2_in = OSD_W'(side1_ff.w);
               oh2_in = sat_osd(hx_full);
            end else begin
               oh2_in = OSD_W'(side1_ff.h);
               ow2_in = sat_osd(wx_full);
            end
         end
         MODE_POST_NAT: begin
            ow2_in = OSD_W'(side1_ff.w);
            oh2_in = OSD_W'(side1_ff.h);
         end
         default: begin
            st2_in = ST_BAD_MODE;
         end
      endcase
      if (st2_in != ST_OK) begin
         ww2_in = '0;
         wh2_in = '0;
         ow2_in = '0;
         oh2_in = '0;
      end
   end

   assign dx = ow2_ff - OSD_W'(ww2_ff);
   assign dy = oh2_ff - OSD_W'(wh2_ff);

   always_comb begin
      rsp3_in.status     = st2_ff;
      rsp3_in.win_width  = ww2_ff;
      rsp3_in.win_height = wh2_ff;
      rsp3_in.win_x      = dx[OSD_W-1:1];
      rsp3_in.win_y      = dy[OSD_W-1:1];
      rsp3_in.osd_w      = ow2_ff;
      rsp3_in.osd_h      = oh2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= i_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      qr1_ff   <= qr1_in;
      side1_ff <= i_quo.side;
      st2_ff   <= st2_in;
      ww2_ff   <= ww2_in;
      wh2_ff   <= wh2_in;
      ow2_ff   <= ow2_in;
      oh2_ff   <= oh2_in;
      rsp3_ff  <= rsp3_in;
   end

   assign o_valid = v3_ff;
   assign o_rsp   = rsp3_ff;

endmodule
